// ===== hdl/block_allocation_map_core_macros.svh =====
// ----------------------------------------------------------------------------
// Block allocation map: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_ALLOCATION_MAP_CORE_MACROS_SVH
`define BLOCK_ALLOCATION_MAP_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BAM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BAM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocation map package
// Opcodes, map word geometry, default sizes and the zero-search result type.
// ----------------------------------------------------------------------------
package bam_pkg;

	// Map word geometry: one bit per block, 64 blocks per word
	localparam int WORD_BITS = 64;
	localparam int WBIT_W    = 6;

	// Default sizes
	localparam int DEF_NUM_BLOCKS     = 1024;
	localparam int DEF_RESERVED_START = 127;
	localparam int DEF_RESERVED_COUNT = 1;

	// Field widths on the stream ports
	localparam int OPCODE_W  = 2;
	localparam int BLK_ID_W  = 11;
	localparam int GRANT_W   = 10;
	localparam int COUNT_W   = 11;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_REQUEST = 2'd1,
		OP_RELEASE = 2'd2
	} bam_op_t;

	// Lowest clear bit of one map word
	typedef struct packed {
		logic              found;
		logic [WBIT_W-1:0] idx;
	} bam_zfind_t;

endpackage

// ===== hdl/bam_zero_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocation map: zero finder
// Priority search for the lowest clear bit of one 64-bit map word.
// ----------------------------------------------------------------------------
module bam_zero_find
	import bam_pkg::*;
(
	input  logic [WORD_BITS-1:0] word,
	output bam_zfind_t           result
);

	// Scan from the top so the lowest clear bit wins
	always_comb begin
		result.found = ~&word;
		result.idx   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				result.idx = WBIT_W'(i);
			end
		end
	end

endmodule

// ===== hdl/block_allocation_map_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocation map core
// Free-block bitmap allocator: allocate lowest free, request named, release.
// ----------------------------------------------------------------------------
// One used bit per block lives in a single-port-write, registered-read RAM of
// ceil(NUM_BLOCKS/64) words of 64 bits. After reset the core writes the
// reserved-block pattern into each map word in turn and holds s_tready low
// until that pass is over. One item is in work at a time. Request and release
// read their word, modify it and write it back. Allocate streams the map words
// out of the RAM one per cycle and stops at the first word with a clear bit,
// or after the last word when the map is full. Every result carries the
// used and free counts after the operation; it sits in an output register so
// the next item is taken while the result waits for m_tready.
// ----------------------------------------------------------------------------
`include "block_allocation_map_core_macros.svh"

module block_allocation_map_core
	import bam_pkg::*;
#(
	parameter int NUM_BLOCKS     = DEF_NUM_BLOCKS,
	parameter int RESERVED_START = DEF_RESERVED_START,
	parameter int RESERVED_COUNT = DEF_RESERVED_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // opcode[1:0], blk_num[12:2], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // ok[0], granted_block[10:1], used_count[21:11],
	                              // free_count[32:22], zero pad
);

	localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
	localparam int RES_END   = (RESERVED_START + RESERVED_COUNT < NUM_BLOCKS) ?
	                           (RESERVED_START + RESERVED_COUNT) : NUM_BLOCKS;
	localparam int RES_N     = (RES_END > RESERVED_START) ? (RES_END - RESERVED_START) : 0;
	localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [WORD_W-1:0]    init_ptr_q;
	bam_op_t              op_q;
	logic [WORD_W-1:0]    wsel_q;
	logic [WBIT_W-1:0]    bsel_q;
	logic [WORD_W-1:0]    ptr_q;
	logic                 iss_q;
	logic                 vld_q;
	logic [WORD_W-1:0]    rword_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 ok_q;
	logic [GRANT_W-1:0]   grant_q;
	logic                 out_vld_q;
	logic [39:0]          out_data_q;

	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	logic                 accept;
	bam_op_t              in_op;
	logic [BLK_ID_W-1:0]  in_id;
	logic [31:0]          id_ext;
	logic                 id_ok;
	logic [WORD_W-1:0]    in_word;
	logic [WBIT_W-1:0]    in_bit;

	logic                 rd_en;
	logic [WORD_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [WORD_W-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	logic                 hit;
	logic [WORD_BITS-1:0] bmask;
	bam_zfind_t           zf;
	logic [31:0]          cand;
	logic                 cand_ok;
	logic [31:0]          used32;
	logic [31:0]          free32;
	logic                 resp_load;

	// Reserved-block pattern for one map word
	function automatic logic [WORD_BITS-1:0] rsv_mask(input logic [WORD_W-1:0] w);
		logic [WORD_BITS-1:0] m;
		int unsigned          blk;
		m = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			blk = 32'(w) * 32'(WORD_BITS) + 32'(b);
			m[b] = (blk >= 32'(RESERVED_START)) &&
			       (blk < 32'(RESERVED_START + RESERVED_COUNT)) &&
			       (blk < 32'(NUM_BLOCKS));
		end
		return m;
	endfunction

	// Decode the incoming transfer
	assign accept  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_op   = bam_op_t'(s_tdata[OPCODE_W-1:0]);
	assign in_id   = s_tdata[OPCODE_W +: BLK_ID_W];
	assign id_ext  = 32'(in_id);
	assign id_ok   = id_ext < 32'(NUM_BLOCKS);
	assign in_word = id_ext[WBIT_W +: WORD_W];
	assign in_bit  = in_id[WBIT_W-1:0];

	// Named-bit test on the word read back
	assign hit   = rdata_q[bsel_q];
	assign bmask = WORD_BITS'(1) << bsel_q;

	// Lowest free block of the word under test
	bam_zero_find u_zero_find (
		.word   (rdata_q),
		.result (zf)
	);

	assign cand    = 32'({rword_q, zf.idx});
	assign cand_ok = cand < 32'(NUM_BLOCKS);

	// Counts reported with each result
	assign used32 = 32'(cnt_q);
	assign free32 = 32'(NUM_BLOCKS) - used32;

	// Load the output register once it is free
	assign resp_load = (state_q == ST_RESP) && (!out_vld_q || m_tready);

	// Steer the map RAM ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = wsel_q;
		wr_data = rdata_q;
		unique case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = init_ptr_q;
				wr_data = rsv_mask(init_ptr_q);
			end
			ST_IDLE: begin
				if (accept && id_ok &&
				    (in_op == OP_REQUEST || in_op == OP_RELEASE)) begin
					rd_en   = 1'b1;
					rd_addr = in_word;
				end
			end
			ST_LOOKUP: begin
				if (op_q == OP_REQUEST && !hit) begin
					wr_en   = 1'b1;
					wr_data = rdata_q | bmask;
				end else if (op_q == OP_RELEASE && hit) begin
					wr_en   = 1'b1;
					wr_data = rdata_q & ~bmask;
				end
			end
			ST_SCAN: begin
				rd_en   = iss_q;
				rd_addr = ptr_q;
				if (vld_q && zf.found && cand_ok) begin
					wr_en   = 1'b1;
					wr_addr = rword_q;
					wr_data = rdata_q | (WORD_BITS'(1) << zf.idx);
				end
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Map RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= map_mem[rd_addr];
		end
	end

	// Sequencer, counts and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_ptr_q <= '0;
			op_q       <= OP_ALLOC;
			wsel_q     <= '0;
			bsel_q     <= '0;
			ptr_q      <= '0;
			iss_q      <= 1'b0;
			vld_q      <= 1'b0;
			rword_q    <= '0;
			cnt_q      <= CNT_W'(RES_N);
			ok_q       <= 1'b0;
			grant_q    <= '0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
		end else begin
			// hold the result until it has been taken
			if (resp_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (init_ptr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end else begin
						init_ptr_q <= init_ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q    <= in_op;
						wsel_q  <= in_word;
						bsel_q  <= in_bit;
						ok_q    <= 1'b0;
						grant_q <= '0;
						unique case (in_op) inside
							OP_ALLOC: begin
								ptr_q   <= '0;
								iss_q   <= 1'b1;
								vld_q   <= 1'b0;
								state_q <= ST_SCAN;
							end
							OP_REQUEST, OP_RELEASE: begin
								state_q <= id_ok ? ST_LOOKUP : ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_LOOKUP: begin
					case (op_q)
						OP_REQUEST: begin
							if (!hit) begin
								ok_q  <= 1'b1;
								cnt_q <= cnt_q + 1'b1;
							end
						end
						OP_RELEASE: begin
							ok_q <= 1'b1;
							if (hit) begin
								cnt_q <= cnt_q - 1'b1;
							end
						end
						default: begin
						end
					endcase
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					// advance the read pointer, stop issuing after the last word
					if (iss_q) begin
						if (ptr_q == LAST_WORD) begin
							iss_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
					vld_q   <= iss_q;
					rword_q <= ptr_q;
					if (vld_q) begin
						if (zf.found) begin
							if (cand_ok) begin
								ok_q    <= 1'b1;
								grant_q <= cand[GRANT_W-1:0];
								cnt_q   <= cnt_q + 1'b1;
							end
							state_q <= ST_RESP;
						end else if (rword_q == LAST_WORD) begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_RESP: begin
					// hold until the output register is free
					if (resp_load) begin
						out_data_q <= {7'd0, free32[COUNT_W-1:0], used32[COUNT_W-1:0],
						               grant_q, ok_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Checks
	`BAM_ASSERT_NEXT(a_one_in_flight, accept, !s_tready, "second transfer taken while busy")
	`BAM_ASSERT_SAME(a_grant_needs_ok, m_tvalid && !m_tdata[0], m_tdata[10:1] == '0, "grant without success")
	`BAM_ASSERT_NEXT(a_count_step, 1'b1, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1)), "used count jumped")

endmodule

// ===== bench/tb_block_allocation_map_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocation map core testbench
// Streams allocate, request and release commands into the core and checks
// every result against a bitmap predictor kept in step at each input
// transfer. A directed opening covers the id and opcode corners. Random
// traffic then fills the map to full, thins it out with releases and mixes
// everything. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_block_allocation_map_core;
	import bam_pkg::*;

	localparam int NUM_BLK     = DEF_NUM_BLOCKS;
	localparam int RES_START   = DEF_RESERVED_START;
	localparam int RES_COUNT   = DEF_RESERVED_COUNT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;

	// Opcode with no operation behind it
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OPCODE_W-1:0] opcode;
		logic [BLK_ID_W-1:0] blk_num;
		bit                  drain;    // hold off until every result is back
	} map_cmd_t;

	// Packed to match m_tdata from bit 0 upwards
	typedef struct packed {
		logic [COUNT_W-1:0] free_count;
		logic [COUNT_W-1:0] used_count;
		logic [GRANT_W-1:0] granted_block;
		logic               ok;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // opcode[1:0], blk_num[12:2], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // ok[0], granted_block[10:1], used_count[21:11],
	                            // free_count[32:22], zero pad

	// Predictor state
	bit block_used [NUM_BLK];
	int blocks_held;

	map_cmd_t      pending_cmds[$];
	alloc_result_t expected_results[$];

	map_cmd_t      next_cmd;
	alloc_result_t got;
	int            accepted_cnt = 0;
	int            delivered_cnt = 0;
	int            mismatch_cnt = 0;
	int            cycle_cnt = 0;
	int            send_gap = 0;
	int            recv_stall = 0;
	bit            send_burst = 1'b0;
	bit            recv_burst = 1'b0;

	block_allocation_map_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one command to the shadow bitmap and return the result it yields
	function automatic alloc_result_t apply_map_op(logic [OPCODE_W-1:0] opcode,
			logic [BLK_ID_W-1:0] blk);
		alloc_result_t r;
		int lowest;
		r = '0;
		lowest = -1;
		case (opcode)
			OP_ALLOC: begin
				for (int i = NUM_BLK - 1; i >= 0; i--)
					if (!block_used[i]) lowest = i;
				if (lowest >= 0) begin
					block_used[lowest] = 1'b1;
					blocks_held++;
					r.ok = 1'b1;
					r.granted_block = GRANT_W'(lowest);
				end
			end
			OP_REQUEST: begin
				if (blk < NUM_BLK && !block_used[blk]) begin
					block_used[blk] = 1'b1;
					blocks_held++;
					r.ok = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (blk < NUM_BLK) begin
					if (block_used[blk]) begin
						block_used[blk] = 1'b0;
						blocks_held--;
					end
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.used_count = COUNT_W'(blocks_held);
		r.free_count = COUNT_W'(NUM_BLK - blocks_held);
		return r;
	endfunction

	function automatic void queue_cmd(logic [OPCODE_W-1:0] opcode, int blk, bit drain = 1'b0);
		map_cmd_t c;
		c.opcode = opcode;
		c.blk_num = BLK_ID_W'(blk);
		c.drain = drain;
		pending_cmds.push_back(c);
	endfunction

	// Driver: predict on each input transfer, then present the next command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
			blocks_held = 0;
			for (int i = 0; i < NUM_BLK; i++) block_used[i] = 1'b0;
			for (int i = RES_START; i < RES_START + RES_COUNT; i++) begin
				if (i < NUM_BLK && !block_used[i]) begin
					block_used[i] = 1'b1;
					blocks_held++;
				end
			end
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_map_op(s_tdata[1:0], s_tdata[12:2]));
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() > 0 &&
						!(pending_cmds[0].drain && accepted_cnt != delivered_cnt)) begin
					next_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, next_cmd.blk_num, next_cmd.opcode};
					if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
					send_gap = send_burst ? 0 : $urandom_range(0, 3);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = alloc_result_t'(m_tdata[32:0]);
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %h", m_tdata);
					mismatch_cnt++;
				end else begin
					automatic alloc_result_t want = expected_results.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						mismatch_cnt++;
					end
					if (got.granted_block !== want.granted_block) begin
						$error("granted_block: expected %0d, got %0d",
							want.granted_block, got.granted_block);
						mismatch_cnt++;
					end
					if (got.used_count !== want.used_count) begin
						$error("used_count: expected %0d, got %0d",
							want.used_count, got.used_count);
						mismatch_cnt++;
					end
					if (got.free_count !== want.free_count) begin
						$error("free_count: expected %0d, got %0d",
							want.free_count, got.free_count);
						mismatch_cnt++;
					end
				end
				delivered_cnt <= delivered_cnt + 1;
				if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
				recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
			end else if (m_tvalid && recv_stall > 0) begin
				recv_stall--;
			end
			m_tready <= (recv_stall == 0);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		int pick;

		// Directed corners: lowest grants, id extremes, out of range ids,
		// request of a used block, release of a free block, unused opcode
		queue_cmd(OP_ALLOC, 0);
		queue_cmd(OP_ALLOC, 2047);
		queue_cmd(OP_REQUEST, RES_START);
		queue_cmd(OP_REQUEST, NUM_BLK - 1);
		queue_cmd(OP_REQUEST, NUM_BLK);
		queue_cmd(OP_REQUEST, 2047);
		queue_cmd(OP_RELEASE, 2047);
		queue_cmd(OP_RELEASE, NUM_BLK);
		queue_cmd(OP_RELEASE, 5);
		queue_cmd(OP_RELEASE, NUM_BLK - 1);
		queue_cmd(OP_RELEASE, RES_START);
		queue_cmd(OP_UNUSED, 2047);
		queue_cmd(OP_UNUSED, 0);
		queue_cmd(OP_REQUEST, 0);
		queue_cmd(OP_RELEASE, 0);
		queue_cmd(OP_ALLOC, 0);
		queue_cmd(OP_REQUEST, RES_START - 1);
		queue_cmd(OP_REQUEST, RES_START + 1);
		queue_cmd(OP_ALLOC, 0);
		queue_cmd(OP_RELEASE, 1);
		queue_cmd(OP_ALLOC, 0);
		queue_cmd(OP_REQUEST, NUM_BLK - 1);
		queue_cmd(OP_RELEASE, NUM_BLK - 1);

		// Fill towards full: mostly allocates, a little noise
		for (int n = 0; n < 1200; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 94) queue_cmd(OP_ALLOC, $urandom_range(0, 2047), n == 0);
			else if (pick < 96) queue_cmd(OP_REQUEST, $urandom_range(0, 2047));
			else if (pick < 98) queue_cmd(OP_RELEASE, $urandom_range(0, 2047));
			else queue_cmd(OP_UNUSED, $urandom_range(0, 2047));
		end

		// Hammer the full map
		for (int n = 0; n < 20; n++) begin
			if (n % 4 == 3) queue_cmd(OP_REQUEST, $urandom_range(0, NUM_BLK - 1));
			else queue_cmd(OP_ALLOC, 0);
		end

		// Punch holes, refill them lowest first
		for (int n = 0; n < 220; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) queue_cmd(OP_RELEASE, $urandom_range(0, NUM_BLK - 1), n == 0);
			else if (pick < 95) queue_cmd(OP_ALLOC, $urandom_range(0, 2047), n == 0);
			else queue_cmd(OP_REQUEST, $urandom_range(0, NUM_BLK - 1), n == 0);
		end

		// Free mix over the whole id range
		for (int n = 0; n < 100; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) queue_cmd(OP_ALLOC, $urandom_range(0, 2047), n == 0);
			else if (pick < 70) queue_cmd(OP_REQUEST, $urandom_range(0, 2047), n == 0);
			else if (pick < 95) queue_cmd(OP_RELEASE, $urandom_range(0, 2047), n == 0);
			else queue_cmd(OP_UNUSED, $urandom_range(0, 2047), n == 0);
		end

		// Hold reset, then release it once
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last transfer and its result, then let the core settle
		while (pending_cmds.size() > 0 || s_tvalid || accepted_cnt != delivered_cnt)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
